FILE: design/gice_pkg.sv
package gice_pkg;

   // Command codes on the result channel
   localparam logic [7:0] CMD_PUNCH   = 8'h30;
   localparam logic [7:0] CMD_CHANGE  = 8'h31;
   localparam logic [7:0] CMD_UP      = 8'h32;
   localparam logic [7:0] CMD_DOWN    = 8'h33;
   localparam logic [7:0] CMD_LEFT    = 8'h34;
   localparam logic [7:0] CMD_RIGHT   = 8'h35;
   localparam logic [7:0] CMD_POWER   = 8'h36;
   localparam logic [7:0] CMD_DEFAULT = 8'h37;
   localparam logic [7:0] NEWLINE     = 8'h0A;

   // Register reset values
   localparam logic [7:0] LOW_THRESHOLD_RESET  = 8'd80;
   localparam logic [7:0] HIGH_THRESHOLD_RESET = 8'd180;
   localparam logic [3:0] DEBOUNCE_TICKS_RESET = 4'd2;
   localparam logic [7:0] RELEASE_TICKS_RESET  = 8'd10;

   localparam logic [2:0] LEVELS_RELEASED = 3'b111;

   // Most commands one request can raise (one per button)
   localparam int MAX_CMDS    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_LEVELS        = 2'd0,
      OP_DEBOUNCE_TICK = 2'd1,
      OP_RELEASE_TICK  = 2'd2,
      OP_AXIS          = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_DEBOUNCE_TICKS = 2'd2,
      CSR_RELEASE_TICKS  = 2'd3
   } csr_index_type;

   // One queued run: cmd_count commands, each later followed by a newline
   typedef struct packed {
      logic [1:0]                 cmd_count;
      logic [MAX_CMDS-1:0][7:0]   cmd_codes;
   } entry_type;

   // Button command codes in emission order: bit 0, bit 1, bit 2
   function automatic logic [7:0] button_code(input logic [1:0] idx);
      logic [7:0] code;
      case (idx)
         2'd0:    code = CMD_PUNCH;
         2'd1:    code = CMD_CHANGE;
         default: code = CMD_POWER;
      endcase
      return code;
   endfunction

endpackage

FILE: design/gice_req_if.sv
interface gice_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [2:0] button_levels;
   logic       axis_select;
   logic [7:0] axis_sample;

   modport source (output valid, operation, button_levels, axis_select, axis_sample,
                   input ready);
   modport sink   (input valid, operation, button_levels, axis_select, axis_sample,
                   output ready);
endinterface

FILE: design/gice_rsp_if.sv
interface gice_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

FILE: design/gice_front.sv
module gice_front (
   input  logic                 clock,
   input  logic                 reset,
   gice_req_if.sink             req_chan,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_write_data,
   input  logic                 push_ready,
   output logic                 push_valid,
   output gice_pkg::entry_type  push_entry
);

   logic [7:0] low_threshold_ff,  low_threshold_in;
   logic [7:0] high_threshold_ff, high_threshold_in;
   logic [3:0] debounce_ticks_ff, debounce_ticks_in;
   logic [7:0] release_ticks_ff,  release_ticks_in;

   logic [2:0] previous_levels_ff,  previous_levels_in;
   logic [2:0] captured_levels_ff,  captured_levels_in;
   logic       debounce_running_ff, debounce_running_in;
   logic [3:0] debounce_count_ff,   debounce_count_in;
   logic       release_armed_ff,    release_armed_in;
   logic [7:0] release_count_ff,    release_count_in;
   logic       x_engaged_ff,        x_engaged_in;
   logic       y_engaged_ff,        y_engaged_in;

   logic                accept;
   gice_pkg::op_type    op;
   gice_pkg::entry_type entry;
   logic [3:0]          debounce_next;
   logic [7:0]          release_next;
   logic                engaged;
   logic                in_low;
   logic                in_high;
   logic [1:0]          n;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign op             = gice_pkg::op_type'(req_chan.operation);
   assign push_valid     = accept && (entry.cmd_count != 2'd0);
   assign push_entry     = entry;

   always_comb begin
      low_threshold_in  = low_threshold_ff;
      high_threshold_in = high_threshold_ff;
      debounce_ticks_in = debounce_ticks_ff;
      release_ticks_in  = release_ticks_ff;
      if (csr_write_enable) begin
         case (gice_pkg::csr_index_type'(csr_index))
            gice_pkg::CSR_LOW_THRESHOLD:  low_threshold_in  = csr_write_data;
            gice_pkg::CSR_HIGH_THRESHOLD: high_threshold_in = csr_write_data;
            gice_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks_in = csr_write_data[3:0];
            gice_pkg::CSR_RELEASE_TICKS:  release_ticks_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      previous_levels_in  = previous_levels_ff;
      captured_levels_in  = captured_levels_ff;
      debounce_running_in = debounce_running_ff;
      debounce_count_in   = debounce_count_ff;
      release_armed_in    = release_armed_ff;
      release_count_in    = release_count_ff;
      x_engaged_in        = x_engaged_ff;
      y_engaged_in        = y_engaged_ff;
      entry               = '0;
      n                   = 2'd0;
      debounce_next       = debounce_count_ff + 4'd1;
      release_next        = release_count_ff + 8'd1;
      engaged             = req_chan.axis_select ? y_engaged_ff : x_engaged_ff;
      in_low              = req_chan.axis_sample <= low_threshold_ff;
      in_high             = req_chan.axis_sample >= high_threshold_ff;

      if (accept) begin
         case (op)
            gice_pkg::OP_LEVELS: begin
               if (req_chan.button_levels != previous_levels_ff && !debounce_running_ff) begin
                  captured_levels_in  = req_chan.button_levels;
                  debounce_running_in = 1'b1;
                  debounce_count_in   = 4'd0;
               end
               previous_levels_in = req_chan.button_levels;
            end
            gice_pkg::OP_DEBOUNCE_TICK: begin
               if (debounce_running_ff) begin
                  if (debounce_next == debounce_ticks_ff) begin
                     debounce_count_in   = 4'd0;
                     debounce_running_in = 1'b0;
                     if (req_chan.button_levels == captured_levels_ff) begin
                        // pack pressed buttons in emission order
                        for (int i = 0; i < gice_pkg::MAX_CMDS; i++) begin
                           if (!captured_levels_ff[i]) begin
                              entry.cmd_codes[n] = gice_pkg::button_code(2'(i));
                              n = n + 2'd1;
                              release_armed_in = 1'b1;
                           end
                        end
                        entry.cmd_count = n;
                     end
                  end else begin
                     debounce_count_in = debounce_next;
                  end
               end
            end
            gice_pkg::OP_RELEASE_TICK: begin
               if (release_armed_ff) begin
                  if (release_next == release_ticks_ff) begin
                     release_count_in   = 8'd0;
                     release_armed_in   = 1'b0;
                     entry.cmd_count    = 2'd1;
                     entry.cmd_codes[0] = gice_pkg::CMD_DEFAULT;
                  end else begin
                     release_count_in = release_next;
                  end
               end
            end
            default: begin
               if (in_low || in_high) begin
                  if (!engaged) begin
                     entry.cmd_count = 2'd1;
                     if (in_low) begin
                        entry.cmd_codes[0] = req_chan.axis_select ? gice_pkg::CMD_LEFT
                                                                  : gice_pkg::CMD_UP;
                     end else begin
                        entry.cmd_codes[0] = req_chan.axis_select ? gice_pkg::CMD_RIGHT
                                                                  : gice_pkg::CMD_DOWN;
                     end
                     if (req_chan.axis_select) y_engaged_in = 1'b1;
                     else                      x_engaged_in = 1'b1;
                  end
               end else if (engaged) begin
                  entry.cmd_count    = 2'd1;
                  entry.cmd_codes[0] = gice_pkg::CMD_DEFAULT;
                  if (req_chan.axis_select) y_engaged_in = 1'b0;
                  else                      x_engaged_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff    <= gice_pkg::LOW_THRESHOLD_RESET;
         high_threshold_ff   <= gice_pkg::HIGH_THRESHOLD_RESET;
         debounce_ticks_ff   <= gice_pkg::DEBOUNCE_TICKS_RESET;
         release_ticks_ff    <= gice_pkg::RELEASE_TICKS_RESET;
         previous_levels_ff  <= gice_pkg::LEVELS_RELEASED;
         captured_levels_ff  <= 3'd0;
         debounce_running_ff <= 1'b0;
         debounce_count_ff   <= 4'd0;
         release_armed_ff    <= 1'b0;
         release_count_ff    <= 8'd0;
         x_engaged_ff        <= 1'b0;
         y_engaged_ff        <= 1'b0;
      end else begin
         low_threshold_ff    <= low_threshold_in;
         high_threshold_ff   <= high_threshold_in;
         debounce_ticks_ff   <= debounce_ticks_in;
         release_ticks_ff    <= release_ticks_in;
         previous_levels_ff  <= previous_levels_in;
         captured_levels_ff  <= captured_levels_in;
         debounce_running_ff <= debounce_running_in;
         debounce_count_ff   <= debounce_count_in;
         release_armed_ff    <= release_armed_in;
         release_count_ff    <= release_count_in;
         x_engaged_ff        <= x_engaged_in;
         y_engaged_ff        <= y_engaged_in;
      end
   end

   // an idle timer holds a zero count
   assert property (@(posedge clock) disable iff (reset)
      !release_armed_ff |-> release_count_ff == 8'd0)
      else $error("release count moved while timer idle");

   assert property (@(posedge clock) disable iff (reset)
      !debounce_running_ff |-> debounce_count_ff == 4'd0)
      else $error("debounce count moved while debounce idle");

endmodule

FILE: design/gice_queue.sv
module gice_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  gice_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output gice_pkg::entry_type  pop_entry
);

   gice_pkg::entry_type slots_ff [gice_pkg::QUEUE_DEPTH];

   logic [gice_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gice_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gice_pkg::QUEUE_PTR_W:0]   count_ff,  count_in;
   logic push;
   logic pop;

   assign push_ready = count_ff != (gice_pkg::QUEUE_PTR_W+1)'(gice_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == gice_pkg::QUEUE_PTR_W'(gice_pkg::QUEUE_DEPTH-1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == gice_pkg::QUEUE_PTR_W'(gice_pkg::QUEUE_DEPTH-1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (gice_pkg::QUEUE_PTR_W+1)'(gice_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

FILE: design/gice_back.sv
module gice_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  gice_pkg::entry_type  pop_entry,
   gice_rsp_if.source           rsp_chan
);

   gice_pkg::entry_type entry_ff, entry_in;
   logic       busy_ff,     busy_in;
   logic [1:0] idx_ff,      idx_in;
   logic       nl_phase_ff, nl_phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff,  out_byte_in;
   logic       last_ff,      last_in;

   logic       out_load;
   logic       is_last_cmd;
   logic       finishing;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.last_of_run = last_ff;

   assign out_load    = !rsp_valid_ff || rsp_chan.ready;
   assign is_last_cmd = idx_ff == entry_ff.cmd_count - 2'd1;
   assign finishing   = busy_ff && out_load && nl_phase_ff && is_last_cmd;
   assign pop_ready   = !busy_ff || finishing;

   always_comb begin
      entry_in     = entry_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      nl_phase_in  = nl_phase_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;

      if (out_load) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            out_byte_in = nl_phase_ff ? gice_pkg::NEWLINE : entry_ff.cmd_codes[idx_ff];
            last_in     = nl_phase_ff && is_last_cmd;
            if (!nl_phase_ff) begin
               nl_phase_in = 1'b1;
            end else if (is_last_cmd) begin
               busy_in = 1'b0;
            end else begin
               idx_in      = idx_ff + 2'd1;
               nl_phase_in = 1'b0;
            end
         end
      end

      if (pop_valid && pop_ready) begin
         entry_in    = pop_entry;
         busy_in     = 1'b1;
         idx_in      = 2'd0;
         nl_phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         nl_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         nl_phase_ff  <= nl_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   // a run always closes on a newline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> out_byte_ff == gice_pkg::NEWLINE)
      else $error("run closed on a command byte");

   // every command byte taken is followed at once by its newline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_chan.ready && out_byte_ff != gice_pkg::NEWLINE
      |=> rsp_valid_ff && out_byte_ff == gice_pkg::NEWLINE)
      else $error("command byte not followed by newline");

endmodule

FILE: design/gamepad_input_command_encoder.sv
// Gamepad command encoder: turns button level samples, debounce and release
// ticks and joystick axis samples into command bytes (0x30 to 0x37), each
// followed by a newline byte, with last_of_run set on the final byte of each
// request's run. A request that raises nothing produces no bytes. The front
// end takes one request per cycle and resolves debounce, release timer and
// axis zones in that same cycle; it stalls only while the two-entry command
// queue is full. The back end drains the queue through a registered output,
// one byte per cycle while the response channel is ready; a request raising
// k commands yields 2k bytes (at most six). Sustained rate is therefore set
// by the output serialiser: silent requests pass one per cycle while the
// queue has room; runs of commands pace later requests. Configuration writes
// take effect on the next cycle and are to be made with no run in flight.
module gamepad_input_command_encoder (
   input  logic       clock,
   input  logic       reset,
   gice_req_if.sink   req_chan,
   gice_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   // queue handshake between classifier and serialiser
   logic                push_valid;
   logic                push_ready;
   gice_pkg::entry_type push_entry;
   logic                pop_valid;
   logic                pop_ready;
   gice_pkg::entry_type pop_entry;

   // classify each request and build its command run
   gice_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   // hold pending runs so either side may stall alone
   gice_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // serialise each run into command and newline bytes
   gice_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule
